[rtl/mie_pkg.sv]
// ============================================================================
// mie_pkg: shared constants for the modular inverse block
// field widths, stream data widths and the modulus reset value
// ============================================================================
package mie_pkg;

    localparam int FIELD_W  = 31;               // width of value, modulus, results
    localparam int COEF_W   = FIELD_W + 3;      // signed bezout coefficient and product
    localparam int REM_W    = FIELD_W + 1;      // partial remainder of the divider
    localparam int CNT_W    = $clog2(FIELD_W);  // divider bit index
    localparam int S_DATA_W = ((FIELD_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((2 * FIELD_W + 7) / 8) * 8;

    localparam logic [FIELD_W-1:0] MOD_RESET = FIELD_W'(1000000007);
    localparam logic [CNT_W-1:0]   BIT_LAST  = CNT_W'(FIELD_W - 1);

endpackage

[rtl/modular_inverse_ext_euclid_top.sv]
// ============================================================================
// modular_inverse_ext_euclid_top: modular inverse by extended euclid
// one value in, one (inverse, gcd) pair out, modulus from a config register
// ============================================================================
// Each input transaction carries a value a; the block runs the extended
// euclidean algorithm against the modulus m and returns the bezout coefficient
// of a reduced into 0..m-1 (the inverse when the gcd is 1) together with
// gcd(a, m). A zero value gives inverse 0 and gcd m; a zero modulus gives
// inverse 0 and gcd a. Timing: one restoring radix-2 divider, shared by every
// euclid step, sets the rate. Each step runs a setup state, a bit-serial divide
// over the 31 quotient bits and an update state; the coefficient product q*t is
// accumulated serially alongside the quotient bits. s_tready is high only
// between items; the result sits in an output register, so the next value is
// taken while it waits.
module modular_inverse_ext_euclid_top
    import mie_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration write channel: modulus
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [FIELD_W-1:0]  cfg_data,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,    // [30:0] value, rest zero
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata     // [30:0] inverse, [61:31] common_divisor
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_DIV,
        ST_UPDATE,
        ST_FIX
    } state_t;

    state_t                    state_reg, state_next;
    logic [FIELD_W-1:0]        modulus_reg, modulus_next;
    // euclid remainders: cb is the dividend side, ca the divisor side
    logic [FIELD_W-1:0]        ca_reg, ca_next;
    logic [FIELD_W-1:0]        cb_reg, cb_next;
    // coefficients of a belonging to cb and ca
    logic signed [COEF_W-1:0]  tb_reg, tb_next;
    logic signed [COEF_W-1:0]  ta_reg, ta_next;
    // divider state
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [FIELD_W-1:0]        dvd_reg, dvd_next;
    logic signed [COEF_W-1:0]  prod_reg, prod_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    // output register
    logic                      out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0]        inv_reg, inv_next;
    logic [FIELD_W-1:0]        gcd_reg, gcd_next;

    // shared divider datapath
    logic [REM_W-1:0]          rem_shift;
    logic [REM_W:0]            rem_diff;
    logic                      q_bit;
    logic signed [COEF_W-1:0]  prod_shift;

    // final reduction
    logic signed [COEF_W-1:0]  mod_ext;
    logic signed [COEF_W-1:0]  x_plus;
    logic signed [COEF_W-1:0]  x_minus;
    logic                      out_free;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(M_DATA_W - 2 * FIELD_W){1'b0}}, gcd_reg, inv_reg};

    // one restoring division step: shift in a dividend bit, trial subtract
    assign rem_shift  = {rem_reg[REM_W-2:0], dvd_reg[FIELD_W-1]};
    assign rem_diff   = {1'b0, rem_shift} - {2'b00, ca_reg};
    assign q_bit      = ~rem_diff[REM_W];
    assign prod_shift = {prod_reg[COEF_W-2:0], 1'b0};

    assign mod_ext  = $signed({{(COEF_W - FIELD_W){1'b0}}, modulus_reg});
    assign x_plus   = tb_reg + mod_ext;
    assign x_minus  = tb_reg - mod_ext;
    assign out_free = ~out_valid_reg | m_tready;

    always_comb
    begin
        state_next     = state_reg;
        modulus_next   = modulus_reg;
        ca_next        = ca_reg;
        cb_next        = cb_reg;
        tb_next        = tb_reg;
        ta_next        = ta_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        prod_next      = prod_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        inv_next       = inv_reg;
        gcd_next       = gcd_reg;

        if (cfg_valid)
        begin
            modulus_next = cfg_data;
        end

        // result transaction taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ca_next    = s_tdata[FIELD_W-1:0];
                    cb_next    = modulus_reg;
                    tb_next    = '0;
                    ta_next    = COEF_W'(1);
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (ca_reg == '0)
                begin
                    state_next = ST_FIX;
                end
                else
                begin
                    rem_next   = '0;
                    dvd_next   = cb_reg;
                    prod_next  = '0;
                    cnt_next   = BIT_LAST;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // quotient bits msb first, product q*ta built alongside
                rem_next  = q_bit ? rem_diff[REM_W-1:0] : rem_shift;
                dvd_next  = {dvd_reg[FIELD_W-2:0], q_bit};
                prod_next = q_bit ? (prod_shift + ta_reg) : prod_shift;
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cb_next    = ca_reg;
                ca_next    = rem_reg[FIELD_W-1:0];
                tb_next    = ta_reg;
                ta_next    = tb_reg - prod_reg;
                state_next = ST_STEP;
            end
            ST_FIX:
            begin
                // wait until the output register is free
                if (out_free)
                begin
                    gcd_next = cb_reg;
                    if (modulus_reg == '0)
                    begin
                        inv_next = '0;
                    end
                    else if (tb_reg[COEF_W-1])
                    begin
                        inv_next = x_plus[FIELD_W-1:0];
                    end
                    else if (!x_minus[COEF_W-1])
                    begin
                        inv_next = x_minus[FIELD_W-1:0];
                    end
                    else
                    begin
                        inv_next = tb_reg[FIELD_W-1:0];
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            modulus_reg   <= MOD_RESET;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            modulus_reg   <= modulus_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        ca_reg   <= ca_next;
        cb_reg   <= cb_next;
        tb_reg   <= tb_next;
        ta_reg   <= ta_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        prod_reg <= prod_next;
        inv_reg  <= inv_next;
        gcd_reg  <= gcd_next;
    end

endmodule
